/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold whenever the antecedent holds at a clock edge
`define RPE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// expression must never be true at a clock edge out of reset
`define RPE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

/* hw/rtl/rpe_pkg.sv */
// rotary position embedding package: widths, types, constants, rom builder
`timescale 1ns / 1ps

package rpe_pkg;

    localparam int unsigned DATA_W   = 16;
    localparam int unsigned SLOT_W   = 5;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned ARG_W    = 30;   // octant angle, q2.30, below 2^30
    localparam int unsigned SC_W     = 31;   // sin / cos, q2.30, up to 2^30
    localparam int unsigned ROM_DEPTH = 32;

    localparam int unsigned HEAD_DIM_DEFAULT = 64;
    localparam int unsigned MAX_POSITION     = 4096;
    localparam longint unsigned STEP_BASE    = 10000;

    // position wrap by reciprocal multiply, exact for any 12 bit position
    localparam int unsigned MOD_W     = 17;
    localparam int unsigned PQ_W      = 8;
    localparam int unsigned RECIP_W   = 14;
    localparam int unsigned POS_SHIFT = POS_W + $clog2(MAX_POSITION);
    localparam longint unsigned POS_RECIP =
        ((64'd1 << POS_SHIFT) + MAX_POSITION - 1) / MAX_POSITION;

    localparam longint unsigned ONE31      = 64'd1 << 31;
    localparam logic [SC_W-1:0] ONE30      = 31'h4000_0000;
    localparam longint unsigned TURN_SCALE = 64'd683565276;
    localparam logic [PHASE_W-1:0] PI_Q30  = 32'hC90F_DAA2;

    // taylor series, horner form, one divisor per step
    localparam int unsigned SERIES_STEPS = 5;
    localparam int unsigned REC_W        = 31;
    localparam int unsigned SIN_DIV [SERIES_STEPS] = '{110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [SERIES_STEPS] = '{132, 90, 56, 30, 12};

    localparam int unsigned PHASE_LAT  = 4;
    localparam int unsigned SINCOS_LAT = 2 * SERIES_STEPS + 1;
    localparam int unsigned ROTATE_LAT = 3;
    localparam int unsigned LATENCY    = PHASE_LAT + SINCOS_LAT + ROTATE_LAT;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] even_value;
        logic signed [DATA_W-1:0] odd_value;
    } pair_t;

    typedef struct packed {
        pair_t      pair;
        logic [1:0] quad;
        logic       swap;
    } rot_side_t;

    typedef logic [PHASE_W-1:0] freq_rom_t [ROM_DEPTH];

    function automatic longint unsigned mul31(input longint unsigned a,
                                              input longint unsigned b);
        return (a * b + (ONE31 >> 1)) >> 31;
    endfunction

    // frequency per pair slot in q0.32 turns per position
    function automatic freq_rom_t build_freq_rom(input int unsigned dim_count);
        freq_rom_t       rom;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned pw;
        longint unsigned f;
        int unsigned     i;
        int unsigned     k;
        lo = 0;
        hi = ONE31;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            pw  = ONE31;
            for (i = 0; i < dim_count; i++) begin
                pw = mul31(pw, mid);
            end
            if (pw * STEP_BASE >= ONE31) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        f = ONE31;
        for (k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = PHASE_W'((f * TURN_SCALE) >> 31);
            f = mul31(mul31(f, hi), hi);
        end
        return rom;
    endfunction

endpackage

/* hw/rtl/rpe_phase.sv */
// phase front end: rom lookup, position wrap, phase multiply, octant fold
`timescale 1ns / 1ps

module rpe_phase #(
    parameter int unsigned HEAD_DIM = rpe_pkg::HEAD_DIM_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  rpe_pkg::pair_t                  in_pair,
    input  logic [rpe_pkg::SLOT_W-1:0]      pair_slot,
    input  logic [rpe_pkg::POS_W-1:0]       token_position,
    output logic                            out_valid,
    output rpe_pkg::rot_side_t              out_side,
    output logic [rpe_pkg::ARG_W-1:0]       out_arg
);

    localparam rpe_pkg::freq_rom_t FREQ_ROM = rpe_pkg::build_freq_rom(HEAD_DIM);
    localparam int unsigned POS_W   = rpe_pkg::POS_W;
    localparam int unsigned PHASE_W = rpe_pkg::PHASE_W;
    localparam int unsigned ARG_W   = rpe_pkg::ARG_W;
    localparam int unsigned PQ_W    = rpe_pkg::PQ_W;
    localparam int unsigned MOD_W   = rpe_pkg::MOD_W;
    localparam int unsigned RECIP_W = rpe_pkg::RECIP_W;
    localparam logic [ARG_W-1:0] HALF_OCT = 30'h2000_0000;
    localparam logic [ARG_W:0]   QUARTER  = 31'h4000_0000;

    // stage 1
    logic                   v1_reg;
    rpe_pkg::pair_t         pair1_reg;
    logic [PHASE_W-1:0]     freq1_reg;
    logic [POS_W-1:0]       pos1_reg;
    logic [PQ_W-1:0]        posq1_reg;
    logic [PQ_W-1:0]        posq1_next;
    logic [POS_W+RECIP_W-1:0] recip_prod;
    // stage 2
    logic                   v2_reg;
    rpe_pkg::pair_t         pair2_reg;
    logic [PHASE_W-1:0]     freq2_reg;
    logic [POS_W-1:0]       pos2_reg;
    logic [POS_W-1:0]       pos2_next;
    logic [PQ_W+MOD_W-1:0]  qm_prod;
    // stage 3
    logic                   v3_reg;
    rpe_pkg::pair_t         pair3_reg;
    logic [PHASE_W-1:0]     phase3_reg;
    logic [POS_W+PHASE_W-1:0] phase_prod;
    // stage 4
    logic                   v4_reg;
    rpe_pkg::rot_side_t     side4_reg;
    rpe_pkg::rot_side_t     side4_next;
    logic [ARG_W-1:0]       arg4_reg;
    logic [ARG_W-1:0]       arg4_next;
    logic [ARG_W-1:0]       rem;
    logic [ARG_W:0]         mirror;
    logic [ARG_W-1:0]       fold;
    logic [ARG_W+PHASE_W-1:0] rad_prod;

    always_comb
    begin
        recip_prod = token_position * RECIP_W'(rpe_pkg::POS_RECIP);
        posq1_next = PQ_W'(recip_prod >> rpe_pkg::POS_SHIFT);
        qm_prod    = posq1_reg * MOD_W'(rpe_pkg::MAX_POSITION);
        pos2_next  = pos1_reg - qm_prod[POS_W-1:0];
        phase_prod = pos2_reg * freq2_reg;

        rem    = phase3_reg[ARG_W-1:0];
        mirror = QUARTER - {1'b0, rem};
        side4_next.pair = pair3_reg;
        side4_next.quad = phase3_reg[PHASE_W-1:PHASE_W-2];
        side4_next.swap = (rem > HALF_OCT);
        fold      = side4_next.swap ? mirror[ARG_W-1:0] : rem;
        rad_prod  = fold * rpe_pkg::PI_Q30;
        arg4_next = rad_prod[ARG_W+30:31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pair1_reg  <= in_pair;
        freq1_reg  <= FREQ_ROM[pair_slot];
        pos1_reg   <= token_position;
        posq1_reg  <= posq1_next;
        pair2_reg  <= pair1_reg;
        freq2_reg  <= freq1_reg;
        pos2_reg   <= pos2_next;
        pair3_reg  <= pair2_reg;
        phase3_reg <= phase_prod[PHASE_W-1:0];
        side4_reg  <= side4_next;
        arg4_reg   <= arg4_next;
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign out_arg   = arg4_reg;

endmodule

/* hw/rtl/rpe_sincos.sv */
// pipelined horner series for sine and cosine over the first octant
`timescale 1ns / 1ps

module rpe_sincos (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [rpe_pkg::ARG_W-1:0]   in_arg,
    output logic                        out_valid,
    output logic [rpe_pkg::SC_W-1:0]    sin_value,
    output logic [rpe_pkg::SC_W-1:0]    cos_value
);

    localparam int unsigned ARG_W = rpe_pkg::ARG_W;
    localparam int unsigned SC_W  = rpe_pkg::SC_W;
    localparam int unsigned REC_W = rpe_pkg::REC_W;
    localparam int unsigned STEPS = rpe_pkg::SERIES_STEPS;
    localparam int unsigned DEPTH = rpe_pkg::SINCOS_LAT;
    localparam int unsigned PROD_W = ARG_W + SC_W;

    logic              valid_reg [DEPTH];
    logic [ARG_W-1:0]  x_reg     [DEPTH-1];
    logic [ARG_W-1:0]  xsq_reg   [DEPTH-1];
    logic [ARG_W-1:0]  qs_reg    [STEPS];
    logic [ARG_W-1:0]  qc_reg    [STEPS];
    logic [ARG_W-1:0]  ps_reg    [STEPS-1];
    logic [ARG_W-1:0]  pc_reg    [STEPS-1];
    logic [ARG_W-1:0]  sin_reg;
    logic [ARG_W-1:0]  cosp_reg;

    logic [2*ARG_W-1:0] sq_prod;
    logic [SC_W-1:0]    ts_last;
    logic [SC_W-1:0]    tc_last;
    logic [PROD_W-1:0]  sin_prod;
    logic [PROD_W-1:0]  cos_prod;

    always_comb
    begin
        sq_prod  = in_arg * in_arg;
        ts_last  = rpe_pkg::ONE30 - {1'b0, qs_reg[STEPS-1]};
        tc_last  = rpe_pkg::ONE30 - {1'b0, qc_reg[STEPS-1]};
        sin_prod = x_reg[DEPTH-2] * ts_last;
        cos_prod = xsq_reg[DEPTH-2] * tc_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= in_arg;
        xsq_reg[0] <= sq_prod[2*ARG_W-1:ARG_W];
        for (int i = 1; i < DEPTH - 1; i++)
        begin
            x_reg[i]   <= x_reg[i-1];
            xsq_reg[i] <= xsq_reg[i-1];
        end
        sin_reg  <= sin_prod[2*ARG_W-1:ARG_W];
        cosp_reg <= cos_prod[2*ARG_W-1:ARG_W];
    end

    // each series term is a multiply stage then an exact constant divide stage; the first term has only the divide
    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam longint unsigned SDIV = rpe_pkg::SIN_DIV[j];
        localparam longint unsigned CDIV = rpe_pkg::COS_DIV[j];
        localparam int unsigned SL = $clog2(SDIV);
        localparam int unsigned CL = $clog2(CDIV);
        localparam longint unsigned SREC = ((64'd1 << (ARG_W + SL)) + SDIV - 1) / SDIV;
        localparam longint unsigned CREC = ((64'd1 << (ARG_W + CL)) + CDIV - 1) / CDIV;

        logic [ARG_W-1:0]       s_dividend;
        logic [ARG_W-1:0]       c_dividend;
        logic [ARG_W+REC_W-1:0] s_div_prod;
        logic [ARG_W+REC_W-1:0] c_div_prod;

        if (j == 0)
        begin : g_first
            assign s_dividend = xsq_reg[0];
            assign c_dividend = xsq_reg[0];
        end
        else
        begin : g_mul
            logic [SC_W-1:0]   ts;
            logic [SC_W-1:0]   tc;
            logic [PROD_W-1:0] s_mul_prod;
            logic [PROD_W-1:0] c_mul_prod;

            always_comb
            begin
                ts = rpe_pkg::ONE30 - {1'b0, qs_reg[j-1]};
                tc = rpe_pkg::ONE30 - {1'b0, qc_reg[j-1]};
                s_mul_prod = xsq_reg[2*j-1] * ts;
                c_mul_prod = xsq_reg[2*j-1] * tc;
            end

            always_ff @(posedge clk)
            begin
                ps_reg[j-1] <= s_mul_prod[2*ARG_W-1:ARG_W];
                pc_reg[j-1] <= c_mul_prod[2*ARG_W-1:ARG_W];
            end

            assign s_dividend = ps_reg[j-1];
            assign c_dividend = pc_reg[j-1];
        end

        always_comb
        begin
            s_div_prod = s_dividend * REC_W'(SREC);
            c_div_prod = c_dividend * REC_W'(CREC);
        end

        always_ff @(posedge clk)
        begin
            qs_reg[j] <= ARG_W'(s_div_prod >> (ARG_W + SL));
            qc_reg[j] <= ARG_W'(c_div_prod >> (ARG_W + CL));
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign sin_value = {1'b0, sin_reg};
    assign cos_value = rpe_pkg::ONE30 - {2'b00, cosp_reg[ARG_W-1:1]};

endmodule

/* hw/rtl/rpe_rotate.sv */
// quadrant restore, pair rotation, rounding and saturation
`timescale 1ns / 1ps

module rpe_rotate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  rpe_pkg::rot_side_t                in_side,
    input  logic [rpe_pkg::SC_W-1:0]          sin_value,
    input  logic [rpe_pkg::SC_W-1:0]          cos_value,
    output logic                              out_valid,
    output logic signed [rpe_pkg::DATA_W-1:0] even_rotated,
    output logic signed [rpe_pkg::DATA_W-1:0] odd_rotated,
    output logic                              clipped
);

    localparam int unsigned DATA_W = rpe_pkg::DATA_W;
    localparam int unsigned TRIG_W = rpe_pkg::SC_W + 1;
    localparam int unsigned MUL_W  = DATA_W + TRIG_W;
    localparam int unsigned SUM_W  = MUL_W + 1;
    localparam int unsigned SH_W   = SUM_W - 30;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'h2000_0000);

    function automatic logic [DATA_W:0] sat16(input logic signed [SH_W-1:0] v);
        logic signed [SH_W-1:0] hi_lim;
        logic signed [SH_W-1:0] lo_lim;
        hi_lim = SH_W'(32767);
        lo_lim = -SH_W'(32768);
        if (v > hi_lim)
        begin
            return {1'b1, 16'h7FFF};
        end
        if (v < lo_lim)
        begin
            return {1'b1, 16'h8000};
        end
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    // stage 1: signed sin and cos of the full angle
    logic                     v1_reg;
    rpe_pkg::pair_t           pair1_reg;
    logic signed [TRIG_W-1:0] sn1_reg;
    logic signed [TRIG_W-1:0] cs1_reg;
    logic signed [TRIG_W-1:0] sn1_next;
    logic signed [TRIG_W-1:0] cs1_next;
    logic signed [TRIG_W-1:0] sr;
    logic signed [TRIG_W-1:0] cr;
    // stage 2: four products
    logic                     v2_reg;
    logic signed [MUL_W-1:0]  p_ec_reg;
    logic signed [MUL_W-1:0]  p_os_reg;
    logic signed [MUL_W-1:0]  p_es_reg;
    logic signed [MUL_W-1:0]  p_oc_reg;
    // stage 3: sum, round, clip
    logic                     v3_reg;
    logic signed [DATA_W-1:0] even_reg;
    logic signed [DATA_W-1:0] odd_reg;
    logic                     clip_reg;
    logic signed [SUM_W-1:0]  e_sum;
    logic signed [SUM_W-1:0]  o_sum;
    logic [DATA_W:0]          e_sat;
    logic [DATA_W:0]          o_sat;

    always_comb
    begin
        if (in_side.swap)
        begin
            sr = signed'({1'b0, cos_value});
            cr = signed'({1'b0, sin_value});
        end
        else
        begin
            sr = signed'({1'b0, sin_value});
            cr = signed'({1'b0, cos_value});
        end
        case (in_side.quad)
            rpe_pkg::QUAD_FIRST:
            begin
                sn1_next = sr;
                cs1_next = cr;
            end
            rpe_pkg::QUAD_SECOND:
            begin
                sn1_next = cr;
                cs1_next = -sr;
            end
            rpe_pkg::QUAD_THIRD:
            begin
                sn1_next = -sr;
                cs1_next = -cr;
            end
            default:
            begin
                sn1_next = -cr;
                cs1_next = sr;
            end
        endcase

        // arithmetic shift of the biased sum rounds half toward +infinity
        e_sum = p_ec_reg - p_os_reg + ROUND_BIAS;
        o_sum = p_es_reg + p_oc_reg + ROUND_BIAS;
        e_sat = sat16(e_sum[SUM_W-1:30]);
        o_sat = sat16(o_sum[SUM_W-1:30]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pair1_reg <= in_side.pair;
        sn1_reg   <= sn1_next;
        cs1_reg   <= cs1_next;
        p_ec_reg  <= pair1_reg.even_value * cs1_reg;
        p_os_reg  <= pair1_reg.odd_value * sn1_reg;
        p_es_reg  <= pair1_reg.even_value * sn1_reg;
        p_oc_reg  <= pair1_reg.odd_value * cs1_reg;
        even_reg  <= e_sat[DATA_W-1:0];
        odd_reg   <= o_sat[DATA_W-1:0];
        clip_reg  <= e_sat[DATA_W] | o_sat[DATA_W];
    end

    assign out_valid    = v3_reg;
    assign even_rotated = even_reg;
    assign odd_rotated  = odd_reg;
    assign clipped      = clip_reg;

endmodule

/* hw/rtl/rotary_position_embedding.sv */
// rotary position embedding top level: phase, sine/cosine series, rotation
`timescale 1ns / 1ps

// usage
// - one even/odd pair of a head vector goes in per word, with its pair slot k
//   and its token position; a word is taken at a rising edge with start high
//   and busy low. busy never rises: the datapath is a fixed pipeline with no
//   back pressure, so a new word may be offered in every cycle
// - each result word sits on even_rotated / odd_rotated / clipped for exactly
//   one cycle while done is high; the receiver cannot stall and must take it
// - pipeline: a word taken at a rising edge passes 4 phase stages, 11 series
//   stages and 3 rotate stages before its done pulse
// - throughput: one word per clock, results leave in input order
// - rate is set by the series pipeline: one multiply or one constant divide
//   per stage, each a register apart
// - reset (rst_n low, asynchronous) clears every valid bit, so words in
//   flight are dropped and no done pulse follows; the frequency rom is a
//   constant table built from HEAD_DIM at elaboration and needs no fill
// - payload ports only carry meaning while done is high

module rotary_position_embedding #(
    parameter int unsigned HEAD_DIM = rpe_pkg::HEAD_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rpe_pkg::DATA_W-1:0] even_value,
    input  logic signed [rpe_pkg::DATA_W-1:0] odd_value,
    input  logic [rpe_pkg::SLOT_W-1:0]        pair_slot,
    input  logic [rpe_pkg::POS_W-1:0]         token_position,
    output logic                              done,
    output logic signed [rpe_pkg::DATA_W-1:0] even_rotated,
    output logic signed [rpe_pkg::DATA_W-1:0] odd_rotated,
    output logic                              clipped
);

    localparam int unsigned SC_LAT = rpe_pkg::SINCOS_LAT;

    logic                          accept;
    rpe_pkg::pair_t                in_pair;

    // phase front end outputs
    logic                          ph_valid;
    rpe_pkg::rot_side_t            ph_side;
    logic [rpe_pkg::ARG_W-1:0]     ph_arg;

    // series outputs
    logic                          sc_valid;
    logic [rpe_pkg::SC_W-1:0]      sc_sin;
    logic [rpe_pkg::SC_W-1:0]      sc_cos;

    // pair and quadrant info ride alongside the series pipeline
    rpe_pkg::rot_side_t            side_reg [SC_LAT];

    // no back pressure anywhere in the pipe
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_pair.even_value = even_value;
    assign in_pair.odd_value  = odd_value;

    rpe_phase #(
        .HEAD_DIM       (HEAD_DIM)
    ) u_phase (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .in_pair        (in_pair),
        .pair_slot      (pair_slot),
        .token_position (token_position),
        .out_valid      (ph_valid),
        .out_side       (ph_side),
        .out_arg        (ph_arg)
    );

    rpe_sincos u_sincos (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (ph_valid),
        .in_arg         (ph_arg),
        .out_valid      (sc_valid),
        .sin_value      (sc_sin),
        .cos_value      (sc_cos)
    );

    // side data delay matches the series latency exactly
    always_ff @(posedge clk)
    begin
        side_reg[0] <= ph_side;
        for (int i = 1; i < SC_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    rpe_rotate u_rotate (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (sc_valid),
        .in_side        (side_reg[SC_LAT-1]),
        .sin_value      (sc_sin),
        .cos_value      (sc_cos),
        .out_valid      (done),
        .even_rotated   (even_rotated),
        .odd_rotated    (odd_rotated),
        .clipped        (clipped)
    );

endmodule

/* hw/rtl/rpe_checker.sv */
// port level checker for the rotary position embedding block, with bind
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rpe_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [rpe_pkg::DATA_W-1:0] even_value,
    input logic signed [rpe_pkg::DATA_W-1:0] odd_value,
    input logic [rpe_pkg::POS_W-1:0]         token_position,
    input logic                              done,
    input logic signed [rpe_pkg::DATA_W-1:0] even_rotated,
    input logic signed [rpe_pkg::DATA_W-1:0] odd_rotated,
    input logic                              clipped
);

    localparam int unsigned LAT = rpe_pkg::LATENCY;

    logic at_rail;

    assign at_rail = (even_rotated == 16'sh7FFF) || (even_rotated == 16'sh8000) ||
                     (odd_rotated == 16'sh7FFF) || (odd_rotated == 16'sh8000);

    // the pipe never pushes back
    `RPE_ASSERT_NEVER(busy_never_set, clk, rst_n, busy)

    // every result word traces back to a word taken a fixed latency earlier
    `RPE_ASSERT_IMPLIES(done_has_source, clk, rst_n, done, $past(start && !busy, LAT))

    // a clipped result has at least one output on a rail
    `RPE_ASSERT_IMPLIES(clip_on_rail, clk, rst_n, done && clipped, at_rail)

    // position zero means angle zero: the pair comes out untouched
    `RPE_ASSERT_IMPLIES(zero_position_identity, clk, rst_n,
        done && $past(token_position == '0, LAT),
        (even_rotated == $past(even_value, LAT)) &&
        (odd_rotated == $past(odd_value, LAT)) && !clipped)

endmodule

bind rotary_position_embedding rpe_checker u_rpe_checker (.*);
